>>> sv/mfpp_pkg.sv
// Shared types, grammar codes and depth tables for the motion-capture packet parser.
package mfpp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
	} byte_t;

	typedef struct packed {
		logic [5:0]  field_kind;
		logic [31:0] field_value;
		logic [15:0] message_kind;
		logic [15:0] outer_index;
		logic [15:0] middle_index;
		logic [15:0] inner_index;
		logic        packet_end;
		logic [1:0]  error_code;
	} field_t;

	// Message ids
	localparam logic [15:0] MSG_FRAME = 16'd7;
	localparam logic [15:0] MSG_DESC  = 16'd5;

	// Error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_COUNT   = 2'd1;
	localparam logic [1:0] ERR_UNKNOWN = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_MAJOR      = 2'd0;
	localparam logic [1:0] REG_MINOR      = 2'd1;
	localparam logic [1:0] REG_MARK_LIM   = 2'd2;
	localparam logic [1:0] REG_BODY_LIM   = 2'd3;

	// Common positions
	localparam logic [5:0] K_MSG_ID = 6'd0;
	localparam logic [5:0] K_SIZE   = 6'd1;
	localparam logic [5:0] POS_IDLE = 6'd62;
	localparam logic [5:0] POS_DROP = 6'd63;

	// Frame grammar
	localparam logic [5:0] F_FRAME_NUM  = 6'd2;
	localparam logic [5:0] F_SET_CNT    = 6'd3;
	localparam logic [5:0] F_SET_NAME   = 6'd4;
	localparam logic [5:0] F_SET_MCNT   = 6'd5;
	localparam logic [5:0] F_SET_MX     = 6'd6;
	localparam logic [5:0] F_SET_MZ     = 6'd8;
	localparam logic [5:0] F_OTH_CNT    = 6'd9;
	localparam logic [5:0] F_OTH_X      = 6'd10;
	localparam logic [5:0] F_OTH_Z      = 6'd12;
	localparam logic [5:0] F_RB_CNT     = 6'd13;
	localparam logic [5:0] F_RB_ID      = 6'd14;
	localparam logic [5:0] F_RB_QW      = 6'd21;
	localparam logic [5:0] F_RB_MCNT    = 6'd22;
	localparam logic [5:0] F_RB_MX      = 6'd23;
	localparam logic [5:0] F_RB_MZ      = 6'd25;
	localparam logic [5:0] F_RB_MID     = 6'd26;
	localparam logic [5:0] F_RB_MSIZE   = 6'd27;
	localparam logic [5:0] F_RB_ERR     = 6'd28;
	localparam logic [5:0] F_SK_CNT     = 6'd29;
	localparam logic [5:0] F_SK_ID      = 6'd30;
	localparam logic [5:0] F_BONE_CNT   = 6'd31;
	localparam logic [5:0] F_BONE_ID    = 6'd32;
	localparam logic [5:0] F_BONE_QW    = 6'd39;
	localparam logic [5:0] F_BM_CNT     = 6'd40;
	localparam logic [5:0] F_BM_X       = 6'd41;
	localparam logic [5:0] F_BM_Z       = 6'd43;
	localparam logic [5:0] F_BM_ID      = 6'd44;
	localparam logic [5:0] F_BM_SIZE    = 6'd45;
	localparam logic [5:0] F_BONE_ERR   = 6'd46;
	localparam logic [5:0] F_LAB_CNT    = 6'd47;
	localparam logic [5:0] F_LAB_ID     = 6'd48;
	localparam logic [5:0] F_LAB_SIZE   = 6'd52;
	localparam logic [5:0] F_LATENCY    = 6'd53;
	localparam logic [5:0] F_END_TAG    = 6'd56;
	localparam int         F_KINDS      = 57;

	// Description grammar
	localparam logic [5:0] D_DS_CNT     = 6'd2;
	localparam logic [5:0] D_TYPE       = 6'd3;
	localparam logic [5:0] D_MS_NAME    = 6'd4;
	localparam logic [5:0] D_MS_CNT     = 6'd5;
	localparam logic [5:0] D_MK_NAME    = 6'd6;
	localparam logic [5:0] D_RB_NAME    = 6'd7;
	localparam logic [5:0] D_RB_ID      = 6'd8;
	localparam logic [5:0] D_RB_OZ      = 6'd12;
	localparam logic [5:0] D_SK_NAME    = 6'd13;
	localparam logic [5:0] D_SK_ID      = 6'd14;
	localparam logic [5:0] D_BONE_CNT   = 6'd15;
	localparam logic [5:0] D_BONE_NAME  = 6'd16;
	localparam logic [5:0] D_BONE_ID    = 6'd17;
	localparam logic [5:0] D_BONE_OZ    = 6'd21;
	localparam int         D_KINDS      = 22;

	// Dataset types
	localparam logic [31:0] DS_MARKERSET = 32'd0;
	localparam logic [31:0] DS_BODY      = 32'd1;
	localparam logic [31:0] DS_SKELETON  = 32'd2;

	// Nesting depth of each field kind
	localparam logic [1:0] FRAME_DEPTH [0:F_KINDS-1] = '{
		2'd0,2'd0,2'd0,2'd0,2'd1,2'd1,2'd2,2'd2,2'd2,2'd0,
		2'd1,2'd1,2'd1,2'd0,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
		2'd1,2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,
		2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,
		2'd2,2'd3,2'd3,2'd3,2'd3,2'd3,2'd2,2'd0,2'd1,2'd1,
		2'd1,2'd1,2'd1,2'd0,2'd0,2'd0,2'd0};
	localparam logic [1:0] DESC_DEPTH [0:D_KINDS-1] = '{
		2'd0,2'd0,2'd0,2'd1,2'd1,2'd1,2'd2,2'd1,2'd1,2'd1,
		2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,
		2'd2,2'd2};

	// Positions that hold a zero-terminated name
	function automatic logic is_name(input logic [15:0] msg, input logic [5:0] pos);
		if (msg == MSG_FRAME) return pos == F_SET_NAME;
		if (msg == MSG_DESC) return pos == D_MS_NAME || pos == D_MK_NAME ||
			pos == D_RB_NAME || pos == D_SK_NAME || pos == D_BONE_NAME;
		return 1'b0;
	endfunction

	// Number of words in the record that starts at a position
	function automatic logic [3:0] rec_len(input logic [15:0] msg, input logic [5:0] pos);
		if (msg == MSG_FRAME) begin
			if (pos == F_SET_MX || pos == F_OTH_X || pos == F_RB_MX || pos == F_BM_X)
				return 4'd3;
			if (pos == F_RB_ID || pos == F_BONE_ID) return 4'd8;
			if (pos == F_LAB_ID) return 4'd5;
			if (pos == F_LATENCY) return 4'd4;
			return 4'd1;
		end
		if (msg == MSG_DESC && (pos == D_RB_ID || pos == D_BONE_ID)) return 4'd5;
		return 4'd1;
	endfunction

endpackage

>>> sv/mocap_frame_packet_parser.sv
// Top level: byte-wide motion-capture packet walker with APB register port.
// Throughput: one byte per cycle; the grammar step is one pass of logic
// between the walk state registers and a two-entry result buffer.
// Input stalls only while both result entries are full.
// Reset: asynchronous, clears the walk to idle and loads register defaults.
module mocap_frame_packet_parser #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  mfpp_pkg::byte_t       byte_data,
	output logic                  field_valid,
	input  logic                  field_stall,
	output mfpp_pkg::field_t      field_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import mfpp_pkg::*;

	localparam int CW = COUNT_WIDTH;

	// Registers
	logic [7:0]  major_q, minor_q;
	logic [15:0] mark_lim_q, body_lim_q;

	// Walk state
	logic [5:0]    pos_q;
	logic [1:0]    bow_q;
	logic [31:0]   acc_q;
	logic [15:0]   msg_q;
	logic [CW-1:0] oc_q, op_q, mc_q, mp_q, ic_q, ip_q;
	logic [3:0]    wir_q;

	logic [5:0]    n_pos;
	logic [1:0]    n_bow;
	logic [31:0]   n_acc;
	logic [15:0]   n_msg;
	logic [CW-1:0] n_oc, n_op, n_mc, n_mp, n_ic, n_ip;
	logic [3:0]    n_wir;

	logic          accept, res_v, do_adv;
	logic [5:0]    k;
	logic [31:0]   v, w, acc2;
	logic [2:0]    bow2;
	logic [4:0]    wir2;
	logic [1:0]    err, depth;
	logic [CW-1:0] wc;
	logic          has_v2, has_skel, has_lab;
	field_t        res;

	// Result buffer
	field_t     head_q, tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	function automatic logic count_bad(input logic [31:0] cw, input logic [15:0] lim,
			input logic limited);
		return ({1'b0, cw} >= (33'd1 << CW)) || (limited && cw >= {16'd0, lim});
	endfunction

	function automatic logic [15:0] idx16(input logic [CW-1:0] p);
		logic [31:0] t;
		t = 32'(p);
		return t[15:0];
	endfunction

	assign pready = 1'b1;
	assign accept = byte_valid && !byte_stall;
	assign byte_stall = cnt_q == 2'd2;
	assign field_valid = cnt_q != 2'd0;
	assign field_data = head_q;
	assign pop = field_valid && !field_stall;

	assign has_v2   = major_q >= 8'd2;
	assign has_skel = (major_q == 8'd2 && minor_q > 8'd0) || major_q > 8'd2;
	assign has_lab  = (major_q == 8'd2 && minor_q >= 8'd3) || major_q > 8'd2;

	// Register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q    <= 8'd2;
			minor_q    <= 8'd3;
			mark_lim_q <= 16'd200;
			body_lim_q <= 16'd20;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_MAJOR:    major_q    <= pwdata[7:0];
				REG_MINOR:    minor_q    <= pwdata[7:0];
				REG_MARK_LIM: mark_lim_q <= pwdata[15:0];
				REG_BODY_LIM: body_lim_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read
	always_comb begin
		case (paddr[3:2])
			REG_MAJOR:    prdata = {24'd0, major_q};
			REG_MINOR:    prdata = {24'd0, minor_q};
			REG_MARK_LIM: prdata = {16'd0, mark_lim_q};
			REG_BODY_LIM: prdata = {16'd0, body_lim_q};
			default:      prdata = 32'd0;
		endcase
	end

	// Grammar step for one byte
	always_comb begin
		n_pos = pos_q; n_bow = bow_q; n_acc = acc_q; n_msg = msg_q;
		n_oc = oc_q; n_op = op_q; n_mc = mc_q; n_mp = mp_q; n_ic = ic_q; n_ip = ip_q;
		n_wir = wir_q;
		res_v = 1'b0; do_adv = 1'b0; k = 6'd0; v = 32'd0; w = 32'd0; err = ERR_NONE;
		acc2 = 32'd0; bow2 = 3'd0; wir2 = 5'd0;
		if (accept && byte_data.packet_start) begin
			n_bow = 2'd0; n_acc = 32'd0; n_msg = 16'd0;
			n_oc = '0; n_op = '0; n_mc = '0; n_mp = '0; n_ic = '0; n_ip = '0;
			n_wir = 4'd0; n_pos = K_MSG_ID;
		end
		if (accept && n_pos < POS_IDLE) begin
			if (n_pos >= F_FRAME_NUM && is_name(n_msg, n_pos)) begin
				// name byte: a zero ends the name
				k = n_pos; v = {24'd0, byte_data.data_byte}; res_v = 1'b1;
				do_adv = byte_data.data_byte == 8'd0;
			end else begin
				// assemble a little-endian word
				acc2 = n_acc | (32'(byte_data.data_byte) << {n_bow, 3'b000});
				bow2 = {1'b0, n_bow} + 3'd1;
				if (bow2 < ((n_pos < F_FRAME_NUM) ? 3'd2 : 3'd4)) begin
					n_acc = acc2; n_bow = bow2[1:0];
				end else begin
					v = acc2; n_acc = 32'd0; n_bow = 2'd0; res_v = 1'b1;
					k = n_pos + {2'd0, n_wir};
					wir2 = {1'b0, n_wir} + 5'd1;
					if (wir2 >= {1'b0, rec_len(n_msg, n_pos)}) begin
						n_wir = 4'd0; do_adv = 1'b1; w = acc2;
					end else begin
						n_wir = wir2[3:0];
					end
				end
			end
		end
		wc = w[CW-1:0];
		if (do_adv) begin
			if (k == K_MSG_ID) begin
				n_msg = w[15:0]; n_pos = K_SIZE;
			end else if (k == K_SIZE) begin
				if (n_msg == MSG_FRAME || n_msg == MSG_DESC) n_pos = F_FRAME_NUM;
				else begin n_pos = POS_DROP; err = ERR_UNKNOWN; end
			end else if (n_msg == MSG_FRAME) begin
				case (k)
					F_FRAME_NUM: n_pos = F_SET_CNT;
					F_SET_CNT: begin
						if (count_bad(w, 16'd0, 1'b0)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							n_oc = wc; n_op = '0;
							if (n_op < n_oc) begin n_mp = '0; n_pos = F_SET_NAME; end
							else n_pos = F_OTH_CNT;
						end
					end
					F_SET_NAME: n_pos = F_SET_MCNT;
					F_SET_MCNT: begin
						if (count_bad(w, mark_lim_q, 1'b1)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							n_mc = wc; n_mp = '0;
							if (w != 32'd0) n_pos = F_SET_MX;
							else begin
								n_op = n_op + 1'b1;
								if (n_op < n_oc) begin n_mp = '0; n_pos = F_SET_NAME; end
								else n_pos = F_OTH_CNT;
							end
						end
					end
					F_SET_MZ: begin
						n_mp = n_mp + 1'b1;
						if (n_mp < n_mc) n_pos = F_SET_MX;
						else begin
							n_op = n_op + 1'b1;
							if (n_op < n_oc) begin n_mp = '0; n_pos = F_SET_NAME; end
							else n_pos = F_OTH_CNT;
						end
					end
					F_OTH_CNT: begin
						if (count_bad(w, mark_lim_q, 1'b1)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							n_oc = wc; n_op = '0;
							n_pos = (w != 32'd0) ? F_OTH_X : F_RB_CNT;
						end
					end
					F_OTH_Z: begin
						n_op = n_op + 1'b1;
						n_pos = (n_op < n_oc) ? F_OTH_X : F_RB_CNT;
					end
					F_RB_CNT: begin
						if (count_bad(w, 16'd0, 1'b0)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							n_oc = wc; n_op = '0;
							if (n_op < n_oc) begin n_mp = '0; n_pos = F_RB_ID; end
							else if (has_skel) n_pos = F_SK_CNT;
							else n_pos = has_lab ? F_LAB_CNT : F_LATENCY;
						end
					end
					F_RB_QW: n_pos = F_RB_MCNT;
					F_RB_MCNT, F_RB_MZ: begin
						if (k == F_RB_MCNT && count_bad(w, body_lim_q, 1'b1)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							if (k == F_RB_MCNT) begin n_mc = wc; n_mp = '0; end
							else n_mp = n_mp + 1'b1;
							if (k == F_RB_MCNT ? (w != 32'd0) : (n_mp < n_mc))
								n_pos = F_RB_MX;
							else begin
								// positions done: ids and sizes follow on v2
								n_mp = '0;
								if (has_v2) n_pos = (n_mc > '0) ? F_RB_MID : F_RB_ERR;
								else begin
									n_op = n_op + 1'b1;
									if (n_op < n_oc) begin n_mp = '0; n_pos = F_RB_ID; end
									else if (has_skel) n_pos = F_SK_CNT;
									else n_pos = has_lab ? F_LAB_CNT : F_LATENCY;
								end
							end
						end
					end
					F_RB_MID: begin
						n_mp = n_mp + 1'b1;
						if (n_mp >= n_mc) begin n_mp = '0; n_pos = F_RB_MSIZE; end
					end
					F_RB_MSIZE: begin
						n_mp = n_mp + 1'b1;
						if (n_mp >= n_mc) n_pos = F_RB_ERR;
					end
					F_RB_ERR: begin
						n_op = n_op + 1'b1;
						if (n_op < n_oc) begin n_mp = '0; n_pos = F_RB_ID; end
						else if (has_skel) n_pos = F_SK_CNT;
						else n_pos = has_lab ? F_LAB_CNT : F_LATENCY;
					end
					F_SK_CNT: begin
						if (count_bad(w, 16'd0, 1'b0)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							n_oc = wc; n_op = '0;
							if (n_op < n_oc) begin n_mp = '0; n_pos = F_SK_ID; end
							else n_pos = has_lab ? F_LAB_CNT : F_LATENCY;
						end
					end
					F_SK_ID: n_pos = F_BONE_CNT;
					F_BONE_CNT, F_BONE_ERR: begin
						if (k == F_BONE_CNT && count_bad(w, 16'd0, 1'b0)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							if (k == F_BONE_CNT) begin n_mc = wc; n_mp = '0; end
							else n_mp = n_mp + 1'b1;
							if (n_mp < n_mc) begin n_ip = '0; n_pos = F_BONE_ID; end
							else begin
								n_op = n_op + 1'b1;
								if (n_op < n_oc) begin n_mp = '0; n_pos = F_SK_ID; end
								else n_pos = has_lab ? F_LAB_CNT : F_LATENCY;
							end
						end
					end
					F_BONE_QW: n_pos = F_BM_CNT;
					F_BM_CNT: begin
						if (count_bad(w, 16'd0, 1'b0)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							n_ic = wc; n_ip = '0;
							n_pos = (w != 32'd0) ? F_BM_X : F_BONE_ERR;
						end
					end
					F_BM_Z, F_BM_ID, F_BM_SIZE: begin
						n_ip = n_ip + 1'b1;
						if (n_ip >= n_ic) begin
							n_ip = '0;
							n_pos = (k == F_BM_Z) ? F_BM_ID :
								((k == F_BM_ID) ? F_BM_SIZE : F_BONE_ERR);
						end else if (k == F_BM_Z) n_pos = F_BM_X;
					end
					F_LAB_CNT: begin
						if (count_bad(w, 16'd0, 1'b0)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							n_oc = wc; n_op = '0;
							n_pos = (n_op < n_oc) ? F_LAB_ID : F_LATENCY;
						end
					end
					F_LAB_SIZE: begin
						n_op = n_op + 1'b1;
						n_pos = (n_op < n_oc) ? F_LAB_ID : F_LATENCY;
					end
					F_END_TAG: n_pos = POS_IDLE;
					default: n_pos = POS_DROP;
				endcase
			end else begin
				case (k)
					D_DS_CNT: begin
						if (count_bad(w, 16'd0, 1'b0)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							n_oc = wc; n_op = '0;
							if (n_op < n_oc) begin n_mp = '0; n_pos = D_TYPE; end
							else n_pos = POS_IDLE;
						end
					end
					D_TYPE: begin
						if (w == DS_MARKERSET) n_pos = D_MS_NAME;
						else if (w == DS_BODY) n_pos = has_v2 ? D_RB_NAME : D_RB_ID;
						else if (w == DS_SKELETON) n_pos = D_SK_NAME;
						else begin
							// unknown dataset: skip to the next one
							n_op = n_op + 1'b1;
							if (n_op < n_oc) begin n_mp = '0; n_pos = D_TYPE; end
							else n_pos = POS_IDLE;
						end
					end
					D_MS_NAME: n_pos = D_MS_CNT;
					D_MS_CNT, D_MK_NAME: begin
						if (k == D_MS_CNT && count_bad(w, 16'd0, 1'b0)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							if (k == D_MS_CNT) begin n_mc = wc; n_mp = '0; end
							else n_mp = n_mp + 1'b1;
							if (n_mp < n_mc) n_pos = D_MK_NAME;
							else begin
								n_op = n_op + 1'b1;
								if (n_op < n_oc) begin n_mp = '0; n_pos = D_TYPE; end
								else n_pos = POS_IDLE;
							end
						end
					end
					D_RB_NAME: n_pos = D_RB_ID;
					D_RB_OZ: begin
						n_op = n_op + 1'b1;
						if (n_op < n_oc) begin n_mp = '0; n_pos = D_TYPE; end
						else n_pos = POS_IDLE;
					end
					D_SK_NAME: n_pos = D_SK_ID;
					D_SK_ID: n_pos = D_BONE_CNT;
					D_BONE_CNT, D_BONE_OZ: begin
						if (k == D_BONE_CNT && count_bad(w, 16'd0, 1'b0)) begin
							n_pos = POS_DROP; err = ERR_COUNT;
						end else begin
							if (k == D_BONE_CNT) begin n_mc = wc; n_mp = '0; end
							else n_mp = n_mp + 1'b1;
							if (n_mp < n_mc) n_pos = has_v2 ? D_BONE_NAME : D_BONE_ID;
							else begin
								n_op = n_op + 1'b1;
								if (n_op < n_oc) begin n_mp = '0; n_pos = D_TYPE; end
								else n_pos = POS_IDLE;
							end
						end
					end
					D_BONE_NAME: n_pos = D_BONE_ID;
					default: n_pos = POS_DROP;
				endcase
			end
		end
	end

	// Build the result with enclosing indices
	always_comb begin
		depth = 2'd0;
		if (n_msg == MSG_FRAME && k < 6'(F_KINDS)) depth = FRAME_DEPTH[k];
		else if (n_msg == MSG_DESC && k < 6'(D_KINDS)) depth = DESC_DEPTH[k[4:0]];
		res.field_kind   = k;
		res.field_value  = v;
		res.message_kind = n_msg;
		res.outer_index  = (depth >= 2'd1) ? idx16(n_op) : 16'd0;
		res.middle_index = (depth >= 2'd2) ? idx16(n_mp) : 16'd0;
		res.inner_index  = (depth >= 2'd3) ? idx16(n_ip) : 16'd0;
		res.packet_end   = n_pos >= POS_IDLE;
		res.error_code   = err;
	end

	// Walk state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE; bow_q <= 2'd0; acc_q <= 32'd0; msg_q <= 16'd0;
			oc_q <= '0; op_q <= '0; mc_q <= '0; mp_q <= '0; ic_q <= '0; ip_q <= '0;
			wir_q <= 4'd0;
		end else begin
			pos_q <= n_pos; bow_q <= n_bow; acc_q <= n_acc; msg_q <= n_msg;
			oc_q <= n_oc; op_q <= n_op; mc_q <= n_mc; mp_q <= n_mp;
			ic_q <= n_ic; ip_q <= n_ip; wir_q <= n_wir;
		end
	end

	// Two-entry result buffer: head drives the port, tail catches overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case (cnt_q)
				2'd0: if (res_v) cnt_q <= 2'd1;
				2'd1: if (res_v && !pop) cnt_q <= 2'd2;
					else if (!res_v && pop) cnt_q <= 2'd0;
				2'd2: if (pop) cnt_q <= 2'd1;
				default: cnt_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: if (res_v) head_q <= res;
			2'd1: begin
				if (res_v && pop) head_q <= res;
				else if (res_v) tail_q <= res;
			end
			2'd2: if (pop) head_q <= tail_q;
			default: ;
		endcase
	end

endmodule

>>> dv/mfpp_scoreboard.sv
// Checker for the motion-capture packet parser: byte-level walk predictor and result compare.
`timescale 1ns / 100ps
module mfpp_scoreboard (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic              byte_stall,
	input  mfpp_pkg::byte_t   byte_data,
	input  logic              field_valid,
	input  logic              field_stall,
	input  mfpp_pkg::field_t  field_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output int                fail_count,
	output int                pending
);
	import mfpp_pkg::*;

	// Register copies
	logic [7:0]  ver_major, ver_minor;
	logic [31:0] mark_lim, body_lim;

	// Walk state
	logic [5:0]  gpos;
	int          byte_idx;
	logic [31:0] word_acc;
	logic [15:0] cur_msg;
	logic [31:0] out_cnt, out_pos, mid_cnt, mid_pos, in_cnt, in_pos;
	int          rec_word;

	field_t      fields_due[$];

	function automatic logic v2_sections();
		return ver_major >= 8'd2;
	endfunction

	function automatic logic skel_sections();
		return (ver_major == 8'd2 && ver_minor > 8'd0) || ver_major > 8'd2;
	endfunction

	function automatic logic labeled_sections();
		return (ver_major == 8'd2 && ver_minor >= 8'd3) || ver_major > 8'd2;
	endfunction

	function automatic logic count_over(logic [31:0] w, logic [31:0] lim, logic limited);
		return w >= 32'h10000 || (limited && w >= lim);
	endfunction

	function automatic logic name_field(logic [15:0] msg, logic [5:0] pos);
		if (msg == MSG_FRAME) return pos == F_SET_NAME;
		if (msg == MSG_DESC) return pos == D_MS_NAME || pos == D_MK_NAME ||
			pos == D_RB_NAME || pos == D_SK_NAME || pos == D_BONE_NAME;
		return 1'b0;
	endfunction

	function automatic int words_in_record(logic [15:0] msg, logic [5:0] pos);
		if (msg == MSG_FRAME) begin
			case (pos)
				F_SET_MX, F_OTH_X, F_RB_MX, F_BM_X: return 3;
				F_RB_ID, F_BONE_ID: return 8;
				F_LAB_ID: return 5;
				F_LATENCY: return 4;
				default: return 1;
			endcase
		end
		if (msg == MSG_DESC && (pos == D_RB_ID || pos == D_BONE_ID)) return 5;
		return 1;
	endfunction

	// Frame section sequencing
	function automatic void lab_loop();
		gpos = (out_pos < out_cnt) ? F_LAB_ID : F_LATENCY;
	endfunction

	function automatic void lab_section();
		gpos = labeled_sections() ? F_LAB_CNT : F_LATENCY;
	endfunction

	function automatic void skel_loop();
		if (out_pos < out_cnt) begin
			mid_pos = 0;
			gpos = F_SK_ID;
		end else lab_section();
	endfunction

	function automatic void bone_loop();
		if (mid_pos < mid_cnt) begin
			in_pos = 0;
			gpos = F_BONE_ID;
		end else begin
			out_pos++;
			skel_loop();
		end
	endfunction

	function automatic void skel_section();
		if (skel_sections()) gpos = F_SK_CNT;
		else lab_section();
	endfunction

	function automatic void body_loop();
		if (out_pos < out_cnt) begin
			mid_pos = 0;
			gpos = F_RB_ID;
		end else skel_section();
	endfunction

	function automatic void body_after_positions();
		mid_pos = 0;
		if (v2_sections()) gpos = (mid_cnt > 0) ? F_RB_MID : F_RB_ERR;
		else begin
			out_pos++;
			body_loop();
		end
	endfunction

	function automatic void set_loop();
		if (out_pos < out_cnt) begin
			mid_pos = 0;
			gpos = F_SET_NAME;
		end else gpos = F_OTH_CNT;
	endfunction

	function automatic logic [1:0] frame_advance(logic [5:0] kind, logic [31:0] w);
		logic bad;
		bad = 1'b0;
		case (kind)
			F_FRAME_NUM: gpos = F_SET_CNT;
			F_SET_CNT: begin
				bad = count_over(w, 0, 1'b0);
				if (!bad) begin
					out_cnt = w; out_pos = 0; set_loop();
				end
			end
			F_SET_NAME: gpos = F_SET_MCNT;
			F_SET_MCNT: begin
				bad = count_over(w, mark_lim, 1'b1);
				if (!bad) begin
					mid_cnt = w; mid_pos = 0;
					if (w > 0) gpos = F_SET_MX;
					else begin
						out_pos++; set_loop();
					end
				end
			end
			F_SET_MZ: begin
				mid_pos++;
				if (mid_pos < mid_cnt) gpos = F_SET_MX;
				else begin
					out_pos++; set_loop();
				end
			end
			F_OTH_CNT: begin
				bad = count_over(w, mark_lim, 1'b1);
				if (!bad) begin
					out_cnt = w; out_pos = 0;
					gpos = (w > 0) ? F_OTH_X : F_RB_CNT;
				end
			end
			F_OTH_Z: begin
				out_pos++;
				gpos = (out_pos < out_cnt) ? F_OTH_X : F_RB_CNT;
			end
			F_RB_CNT: begin
				bad = count_over(w, 0, 1'b0);
				if (!bad) begin
					out_cnt = w; out_pos = 0; body_loop();
				end
			end
			F_RB_QW: gpos = F_RB_MCNT;
			F_RB_MCNT: begin
				bad = count_over(w, body_lim, 1'b1);
				if (!bad) begin
					mid_cnt = w; mid_pos = 0;
					if (w > 0) gpos = F_RB_MX;
					else body_after_positions();
				end
			end
			F_RB_MZ: begin
				mid_pos++;
				if (mid_pos < mid_cnt) gpos = F_RB_MX;
				else body_after_positions();
			end
			F_RB_MID: begin
				mid_pos++;
				if (mid_pos >= mid_cnt) begin
					mid_pos = 0; gpos = F_RB_MSIZE;
				end
			end
			F_RB_MSIZE: begin
				mid_pos++;
				if (mid_pos >= mid_cnt) gpos = F_RB_ERR;
			end
			F_RB_ERR: begin
				out_pos++; body_loop();
			end
			F_SK_CNT: begin
				bad = count_over(w, 0, 1'b0);
				if (!bad) begin
					out_cnt = w; out_pos = 0; skel_loop();
				end
			end
			F_SK_ID: gpos = F_BONE_CNT;
			F_BONE_CNT: begin
				bad = count_over(w, 0, 1'b0);
				if (!bad) begin
					mid_cnt = w; mid_pos = 0; bone_loop();
				end
			end
			F_BONE_QW: gpos = F_BM_CNT;
			F_BM_CNT: begin
				bad = count_over(w, 0, 1'b0);
				if (!bad) begin
					in_cnt = w; in_pos = 0;
					gpos = (w > 0) ? F_BM_X : F_BONE_ERR;
				end
			end
			F_BM_Z, F_BM_ID, F_BM_SIZE: begin
				in_pos++;
				if (in_pos >= in_cnt) begin
					in_pos = 0;
					gpos = (kind == F_BM_Z) ? F_BM_ID : ((kind == F_BM_ID) ? F_BM_SIZE : F_BONE_ERR);
				end else if (kind == F_BM_Z) gpos = F_BM_X;
			end
			F_BONE_ERR: begin
				mid_pos++; bone_loop();
			end
			F_LAB_CNT: begin
				bad = count_over(w, 0, 1'b0);
				if (!bad) begin
					out_cnt = w; out_pos = 0; lab_loop();
				end
			end
			F_LAB_SIZE: begin
				out_pos++; lab_loop();
			end
			F_END_TAG: gpos = POS_IDLE;
			default: gpos = POS_DROP;
		endcase
		if (bad) begin
			gpos = POS_DROP;
			return ERR_COUNT;
		end
		return ERR_NONE;
	endfunction

	// Description section sequencing
	function automatic void dataset_loop();
		if (out_pos < out_cnt) begin
			mid_pos = 0; gpos = D_TYPE;
		end else gpos = POS_IDLE;
	endfunction

	function automatic void marker_name_loop();
		if (mid_pos < mid_cnt) gpos = D_MK_NAME;
		else begin
			out_pos++; dataset_loop();
		end
	endfunction

	function automatic void desc_bone_loop();
		if (mid_pos < mid_cnt) gpos = v2_sections() ? D_BONE_NAME : D_BONE_ID;
		else begin
			out_pos++; dataset_loop();
		end
	endfunction

	function automatic logic [1:0] desc_advance(logic [5:0] kind, logic [31:0] w);
		logic bad;
		bad = 1'b0;
		case (kind)
			D_DS_CNT: begin
				bad = count_over(w, 0, 1'b0);
				if (!bad) begin
					out_cnt = w; out_pos = 0; dataset_loop();
				end
			end
			D_TYPE: begin
				if (w == DS_MARKERSET) gpos = D_MS_NAME;
				else if (w == DS_BODY) gpos = v2_sections() ? D_RB_NAME : D_RB_ID;
				else if (w == DS_SKELETON) gpos = D_SK_NAME;
				else begin
					out_pos++; dataset_loop();
				end
			end
			D_MS_NAME: gpos = D_MS_CNT;
			D_MS_CNT: begin
				bad = count_over(w, 0, 1'b0);
				if (!bad) begin
					mid_cnt = w; mid_pos = 0; marker_name_loop();
				end
			end
			D_MK_NAME: begin
				mid_pos++; marker_name_loop();
			end
			D_RB_NAME: gpos = D_RB_ID;
			D_RB_OZ: begin
				out_pos++; dataset_loop();
			end
			D_SK_NAME: gpos = D_SK_ID;
			D_SK_ID: gpos = D_BONE_CNT;
			D_BONE_CNT: begin
				bad = count_over(w, 0, 1'b0);
				if (!bad) begin
					mid_cnt = w; mid_pos = 0; desc_bone_loop();
				end
			end
			D_BONE_NAME: gpos = D_BONE_ID;
			D_BONE_OZ: begin
				mid_pos++; desc_bone_loop();
			end
			default: gpos = POS_DROP;
		endcase
		if (bad) begin
			gpos = POS_DROP;
			return ERR_COUNT;
		end
		return ERR_NONE;
	endfunction

	function automatic logic [1:0] walk_advance(logic [5:0] kind, logic [31:0] w);
		if (kind == K_MSG_ID) begin
			cur_msg = w[15:0];
			gpos = K_SIZE;
			return ERR_NONE;
		end
		if (kind == K_SIZE) begin
			if (cur_msg == MSG_FRAME || cur_msg == MSG_DESC) begin
				gpos = F_FRAME_NUM;
				return ERR_NONE;
			end
			gpos = POS_DROP;
			return ERR_UNKNOWN;
		end
		if (cur_msg == MSG_FRAME) return frame_advance(kind, w);
		return desc_advance(kind, w);
	endfunction

	function automatic void clear_walk();
		byte_idx = 0; word_acc = '0; cur_msg = '0;
		out_cnt = 0; out_pos = 0; mid_cnt = 0; mid_pos = 0;
		in_cnt = 0; in_pos = 0; rec_word = 0;
	endfunction

	// Walk one byte; queue the field it completes, if any
	function automatic void walk_byte(byte_t in);
		logic [5:0]  pos, kind;
		logic [31:0] val;
		logic [1:0]  err;
		int          depth, need;
		field_t      f;
		err = ERR_NONE;
		depth = 0;
		if (in.packet_start) begin
			clear_walk();
			gpos = K_MSG_ID;
		end
		if (gpos >= POS_IDLE) return;
		pos = gpos;
		if (pos >= F_FRAME_NUM && name_field(cur_msg, pos)) begin
			kind = pos;
			val = {24'd0, in.data_byte};
			if (in.data_byte == 8'd0) err = walk_advance(kind, 32'd0);
		end else begin
			need = (pos < F_FRAME_NUM) ? 2 : 4;
			word_acc |= {24'd0, in.data_byte} << (8 * byte_idx);
			byte_idx++;
			if (byte_idx < need) return;
			val = word_acc;
			word_acc = '0;
			byte_idx = 0;
			kind = pos + 6'(rec_word);
			rec_word++;
			if (rec_word >= words_in_record(cur_msg, pos)) begin
				rec_word = 0;
				err = walk_advance(kind, val);
			end
		end
		if (cur_msg == MSG_FRAME && kind < F_KINDS) depth = FRAME_DEPTH[kind];
		else if (cur_msg == MSG_DESC && kind < D_KINDS) depth = DESC_DEPTH[kind[4:0]];
		f.field_kind   = kind;
		f.field_value  = val;
		f.message_kind = cur_msg;
		f.outer_index  = (depth >= 1) ? out_pos[15:0] : 16'd0;
		f.middle_index = (depth >= 2) ? mid_pos[15:0] : 16'd0;
		f.inner_index  = (depth >= 3) ? in_pos[15:0] : 16'd0;
		f.packet_end   = (gpos >= POS_IDLE);
		f.error_code   = err;
		fields_due.push_back(f);
	endfunction

	assign pending = fields_due.size();

	// Compare result transfers, then predict from byte transfers
	always @(posedge clk or negedge arst_n) begin
		field_t exp_f;
		if (!arst_n) begin
			ver_major <= 8'd2;
			ver_minor <= 8'd3;
			mark_lim <= 32'd200;
			body_lim <= 32'd20;
			clear_walk();
			gpos = POS_IDLE;
			fields_due.delete();
			fail_count <= 0;
		end else begin
			if (field_valid && !field_stall) begin
				if (fields_due.size() == 0) begin
					$display("%0t: unexpected result expected none actual %p",
						$time, field_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_f = fields_due.pop_front();
					if (field_data !== exp_f) begin
						$display("%0t: result mismatch expected %p actual %p",
							$time, exp_f, field_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (byte_valid && !byte_stall) walk_byte(byte_data);
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MAJOR:    ver_major <= pwdata[7:0];
					REG_MINOR:    ver_minor <= pwdata[7:0];
					REG_MARK_LIM: mark_lim <= {16'd0, pwdata[15:0]};
					REG_BODY_LIM: body_lim <= {16'd0, pwdata[15:0]};
					default: ;
				endcase
			end
		end
	end

endmodule

>>> dv/tb_mocap_frame_packet_parser.sv
// Testbench top: packet stimulus, register phases and verdict for the packet parser.
`timescale 1ns / 100ps
module tb_mocap_frame_packet_parser;
	import mfpp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	byte_t       byte_data;
	logic        field_valid;
	logic        field_stall;
	field_t      field_data;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          fail_count, pending;

	// Generator state
	byte_t       stream_q[$];
	logic        broken;
	int          cut_left;
	logic [7:0]  gen_major, gen_minor;
	int          gen_mark_lim, gen_body_lim;
	logic        calm_in;

	mocap_frame_packet_parser DUT (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .byte_data(byte_data),
		.field_valid(field_valid), .field_stall(field_stall), .field_data(field_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mfpp_scoreboard checker_i (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .byte_data(byte_data),
		.field_valid(field_valid), .field_stall(field_stall), .field_data(field_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_mocap_frame_packet_parser failed");
		$finish;
	end

	// Result-side stall: random stretches of heavy, light, sticky or no backpressure
	initial begin
		int mode, left;
		field_stall = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(10, 200);
			end
			left--;
			case (mode)
				0: field_stall <= 1'b0;
				1: field_stall <= ($urandom_range(0, 9) < 2);
				2: field_stall <= ($urandom_range(0, 9) < 7);
				default: field_stall <= ($urandom_range(0, 99) < 3) ? 1'b1 : field_stall;
			endcase
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm_in || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Stream assembly
	function automatic void put_byte(logic [7:0] b, logic st);
		byte_t item;
		if (broken) return;
		if (cut_left == 0) begin
			broken = 1'b1;
			return;
		end
		cut_left--;
		item.data_byte = b;
		item.packet_start = st;
		stream_q.push_back(item);
	endfunction

	function automatic void put_word(logic [31:0] w);
		for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8], 1'b0);
	endfunction

	function automatic void put_name();
		int n;
		n = $urandom_range(0, 4);
		repeat (n) put_byte(8'($urandom_range(1, 255)), 1'b0);
		put_byte(8'd0, 1'b0);
	endfunction

	// Emit a count; now and then an out-of-range one that drops the packet
	function automatic int put_count(int maxn, logic limited, int lim);
		int n;
		n = $urandom_range(0, maxn);
		if ($urandom_range(0, 99) < 3) begin
			put_word($urandom() | 32'h10000);
			broken = 1'b1;
			return 0;
		end
		if (limited && $urandom_range(0, 99) < 3) n = lim;
		put_word(n);
		if (limited && n >= lim) begin
			broken = 1'b1;
			return 0;
		end
		return n;
	endfunction

	function automatic void start_packet(logic [15:0] id);
		broken = 1'b0;
		cut_left = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 60) : 32'h7fffffff;
		put_byte(id[7:0], 1'b1);
		put_byte(id[15:8], 1'b0);
		put_byte(8'($urandom()), 1'b0);
		put_byte(8'($urandom()), 1'b0);
	endfunction

	function automatic void build_frame();
		int sets, mk, others, bodies, sk, bones, bm, labs;
		logic v2, skel, lab;
		v2 = gen_major >= 8'd2;
		skel = (gen_major == 8'd2 && gen_minor > 8'd0) || gen_major > 8'd2;
		lab = (gen_major == 8'd2 && gen_minor >= 8'd3) || gen_major > 8'd2;
		start_packet(MSG_FRAME);
		put_word($urandom());
		sets = put_count(3, 1'b0, 0);
		for (int s = 0; s < sets; s++) begin
			put_name();
			mk = put_count(3, 1'b1, gen_mark_lim);
			repeat (3 * mk) put_word($urandom());
		end
		others = put_count(3, 1'b1, gen_mark_lim);
		repeat (3 * others) put_word($urandom());
		bodies = put_count(3, 1'b0, 0);
		for (int b = 0; b < bodies; b++) begin
			repeat (8) put_word($urandom());
			mk = put_count(3, 1'b1, gen_body_lim);
			repeat (3 * mk) put_word($urandom());
			if (v2) repeat (2 * mk + 1) put_word($urandom());
		end
		if (skel) begin
			sk = put_count(2, 1'b0, 0);
			for (int k = 0; k < sk; k++) begin
				put_word($urandom());
				bones = put_count(2, 1'b0, 0);
				for (int j = 0; j < bones; j++) begin
					repeat (8) put_word($urandom());
					bm = put_count(2, 1'b0, 0);
					repeat (5 * bm + 1) put_word($urandom());
				end
			end
		end
		if (lab) begin
			labs = put_count(3, 1'b0, 0);
			repeat (5 * labs) put_word($urandom());
		end
		repeat (4) put_word($urandom());
	endfunction

	function automatic void build_desc();
		int sets, n, bones, r;
		logic v2;
		v2 = gen_major >= 8'd2;
		start_packet(MSG_DESC);
		sets = put_count(3, 1'b0, 0);
		for (int d = 0; d < sets; d++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				put_word(DS_MARKERSET);
				put_name();
				n = put_count(3, 1'b0, 0);
				repeat (n) put_name();
			end else if (r < 60) begin
				put_word(DS_BODY);
				if (v2) put_name();
				repeat (5) put_word($urandom());
			end else if (r < 90) begin
				put_word(DS_SKELETON);
				put_name();
				put_word($urandom());
				bones = put_count(2, 1'b0, 0);
				for (int j = 0; j < bones; j++) begin
					if (v2) put_name();
					repeat (5) put_word($urandom());
				end
			end else begin
				put_word(($urandom_range(0, 1) == 0) ? 32'd3 : ($urandom() | 32'd3));
			end
		end
	endfunction

	// Mostly well-formed packets; some unknown ids, cut packets and stray bytes
	function automatic void build_packet();
		int r;
		logic [15:0] id;
		r = $urandom_range(0, 99);
		if (r < 55) build_frame();
		else if (r < 88) build_desc();
		else begin
			id = 16'($urandom());
			if (id == MSG_FRAME || id == MSG_DESC) id = ~id;
			start_packet(id);
		end
		if ($urandom_range(0, 9) < 2) begin
			broken = 1'b0;
			cut_left = 32'h7fffffff;
			repeat ($urandom_range(1, 6)) put_byte(8'($urandom()), 1'b0);
		end
	endfunction

	task automatic send_stream();
		byte_t item;
		int g;
		calm_in = 1'b0;
		while (stream_q.size() != 0) begin
			if ($urandom_range(0, 99) == 0) calm_in = ~calm_in;
			item = stream_q.pop_front();
			g = gap_len();
			if (g > 0) begin
				byte_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			byte_valid <= 1'b1;
			byte_data <= item;
			do @(posedge clk); while (byte_stall);
		end
		byte_valid <= 1'b0;
	endtask

	// Let the checker see the last byte transfer before its queue is read
	task automatic wait_idle();
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_regs(logic [7:0] maj, logic [7:0] mnr, int mlim, int blim);
		reg_write(REG_MAJOR, 32'(maj));
		reg_write(REG_MINOR, 32'(mnr));
		reg_write(REG_MARK_LIM, 32'(mlim));
		reg_write(REG_BODY_LIM, 32'(blim));
		gen_major = maj;
		gen_minor = mnr;
		gen_mark_lim = mlim;
		gen_body_lim = blim;
	endtask

	initial begin
		logic [7:0] maj_tab [7] = '{8'd2, 8'd1, 8'd2, 8'd2, 8'd3, 8'd255, 8'd0};
		logic [7:0] min_tab [7] = '{8'd3, 8'd0, 8'd0, 8'd2, 8'd0, 8'd255, 8'd255};
		int mlim_tab [7] = '{200, 65535, 0, 3, 5, 65535, 1};
		int blim_tab [7] = '{20, 65535, 0, 2, 3, 1, 0};
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm_in = 1'b0;
		broken = 1'b0;
		cut_left = 32'h7fffffff;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < 7; p++) begin
			set_regs(maj_tab[p], min_tab[p], mlim_tab[p], blim_tab[p]);
			if (p == 0) begin
				// Stray bytes, an unknown id, an empty description, an early restart, an out-of-range count
				put_byte(8'hFF, 1'b0);
				put_byte(8'h00, 1'b0);
				put_byte(8'hFF, 1'b1);
				put_byte(8'hFF, 1'b0);
				put_byte(8'h00, 1'b0);
				put_byte(8'h00, 1'b0);
				put_byte(8'h77, 1'b0);
				put_byte(MSG_DESC[7:0], 1'b1);
				put_byte(8'h00, 1'b0);
				put_byte(8'h00, 1'b0);
				put_byte(8'h00, 1'b0);
				put_word(32'd0);
				put_byte(8'hA5, 1'b0);
				put_byte(MSG_FRAME[7:0], 1'b1);
				put_byte(8'h00, 1'b0);
				put_byte(8'hFF, 1'b0);
				put_byte(MSG_DESC[7:0], 1'b1);
				put_byte(8'h00, 1'b0);
				put_byte(8'h00, 1'b0);
				put_byte(8'h00, 1'b0);
				put_word(32'hFFFFFFFF);
				send_stream();
				wait_idle();
			end
			while (stream_q.size() < 220) build_packet();
			send_stream();
			wait_idle();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("tb_mocap_frame_packet_parser passed");
		end else begin
			$display("tb_mocap_frame_packet_parser failed");
		end
		$finish;
	end

endmodule
